[rtl/core/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque unit
// ----------------------------------------------------------------------------
package cdq_pkg;

  // default geometry
  localparam int unsigned DEPTH_DEF      = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed payload widths of the channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_REJ_FULL = 2'd1,
    ST_REJ_EMPT = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell, already qualified
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

[rtl/core/cdq_in_if.sv]
// ----------------------------------------------------------------------------
// cdq_in_if
// request channel: one deque operation per transfer
// ----------------------------------------------------------------------------
interface cdq_in_if
  import cdq_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             operation;
  logic signed [VALUE_W-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

[rtl/core/cdq_out_if.sv]
// ----------------------------------------------------------------------------
// cdq_out_if
// response channel: one result per request
// ----------------------------------------------------------------------------
interface cdq_out_if
  import cdq_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_W-1:0]   popped_value;
  logic [STATUS_W-1:0]         status;
  logic [OCC_W-1:0]            occupancy;
  logic                        is_full;
  logic                        is_empty;

  modport source (output valid, output popped_value, output status,
                  output occupancy, output is_full, output is_empty, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input occupancy, input is_full, input is_empty, output ready);
endinterface

[rtl/core/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell
// one storage slot of the deque chain, slot 0 holds the front entry
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned IDX        = 0,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] prev_data_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  last_o
);

  localparam logic [CNT_W-1:0] SLOT     = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_front) begin
      data_d = prev_data_i;
    end else if (ctrl_i.pop_front) begin
      data_d = next_data_i;
    end else if (ctrl_i.push_rear && (cnt_i == SLOT)) begin
      data_d = word_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign last_o = (cnt_i == SLOT_END);

endmodule

[rtl/core/cdq_rear_sel.sv]
// ----------------------------------------------------------------------------
// cdq_rear_sel
// picks the rear entry of the chain from the one-hot last-slot flags
// ----------------------------------------------------------------------------
module cdq_rear_sel
  import cdq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = DEPTH_DEF
) (
  input  logic [DATA_WIDTH-1:0] data_i [DEPTH],
  input  logic [DEPTH-1:0]      last_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  always_comb begin
    data_o = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      data_o = data_o | (data_i[i] & {DATA_WIDTH{last_i[i]}});
    end
  end

endmodule

[rtl/core/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// double-ended queue of DEPTH words held in a shifting chain of cells
// ----------------------------------------------------------------------------
// usage
//   in_i carries one request per transfer: push front, push rear, pop front
//   or pop rear, with the word to push. out_o returns exactly one result per
//   request: the popped word (zero unless a pop succeeded), a status (done,
//   rejected full, rejected empty), the occupancy and the full/empty flags.
//   a result is offered in the cycle after its request transfer.
//   throughput: one request per cycle unless out_o stalls. the chain updates
//   in the cycle of the transfer, and the result sits in an output register,
//   so the next request is taken in the cycle that result transfers on out_o.
//   when the receiver stalls with a result pending, in_i.ready drops until
//   the pending result transfers; nothing is lost or repeated.
//   reset empties the deque (count to zero) and clears the output valid; the
//   cell contents stay undefined until pushed and are never read before then.
//   a rejected request changes nothing in the chain.
// ----------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // occupancy count, the only control state of the deque
  logic [CNT_W-1:0] cnt_d, cnt_q;

  // output register
  logic                      out_valid_d, out_valid_q;
  logic signed [VALUE_W-1:0] popped_q;
  logic [STATUS_W-1:0]       status_q;
  logic [OCC_W-1:0]          occ_q;
  logic                      full_q, empty_q;

  logic        xfer_in;
  op_e         op;
  status_e     status;
  logic        is_full, is_empty;
  logic        ok;
  cell_ctrl_t  ctrl;

  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_last;
  logic [DATA_WIDTH-1:0] rear_data;
  logic [DATA_WIDTH-1:0] pop_data;
  logic [VALUE_W-1:0]    popped;

  // take a new request whenever the result slot is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign xfer_in    = in_i.valid && in_i.ready;

  assign op       = op_e'(in_i.operation);
  assign is_full  = (cnt_q == CNT_FULL);
  assign is_empty = (cnt_q == '0);

  // stored word: low DATA_WIDTH bits of the request value, zero extended
  assign word = DATA_WIDTH'(64'($unsigned(in_i.value)));

  // decode and qualify the request against the current occupancy
  always_comb begin
    status = ST_DONE;
    unique case (op) inside
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (is_full) status = ST_REJ_FULL;
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (is_empty) status = ST_REJ_EMPT;
      end
      default: status = ST_DONE;
    endcase
  end

  assign ok = xfer_in && (status == ST_DONE);

  assign ctrl.push_front = ok && (op == OP_PUSH_FRONT);
  assign ctrl.push_rear  = ok && (op == OP_PUSH_REAR);
  assign ctrl.pop_front  = ok && (op == OP_POP_FRONT);
  assign ctrl.pop_rear   = ok && (op == OP_POP_REAR);

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.push_front || ctrl.push_rear) begin
      cnt_d = cnt_q + CNT_ONE;
    end else if (ctrl.pop_front || ctrl.pop_rear) begin
      cnt_d = cnt_q - CNT_ONE;
    end
  end

  // chain of cells: slot 0 is the front, slot cnt-1 the rear
  // push front shifts toward the rear, pop front shifts toward the front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;

    if (g == 0) begin : g_head
      assign prev_data = word;
    end else begin : g_body
      assign prev_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign next_data = '0;
    end else begin : g_link
      assign next_data = cell_data[g+1];
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .IDX        (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cnt_i       (cnt_q),
      .word_i      (word),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .last_o      (cell_last[g])
    );
  end

  cdq_rear_sel #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_rear_sel (
    .data_i (cell_data),
    .last_i (cell_last),
    .data_o (rear_data)
  );

  // popped word: front from slot 0, rear from the last occupied slot
  always_comb begin
    pop_data = '0;
    if (ctrl.pop_front) begin
      pop_data = cell_data[0];
    end else if (ctrl.pop_rear) begin
      pop_data = rear_data;
    end
  end

  assign popped = VALUE_W'(64'(pop_data));

  // result slot is freed by a transfer on out_o and refilled by a request
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (xfer_in) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded with each request transfer
  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      popped_q <= popped;
      status_q <= status;
      occ_q    <= OCC_W'(cnt_d);
      full_q   <= (cnt_d == CNT_FULL);
      empty_q  <= (cnt_d == '0);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.status       = status_q;
  assign out_o.occupancy    = occ_q;
  assign out_o.is_full      = full_q;
  assign out_o.is_empty     = empty_q;

endmodule
